// File: hdl/multichannel_average_minmax_threshold_top_macros.svh
// Assertion macros shared by the block's RTL modules.
// Expects a clock named clk and an active-high reset named rst in scope.
`ifndef MULTICHANNEL_AVERAGE_MINMAX_THRESHOLD_TOP_MACROS_SVH
`define MULTICHANNEL_AVERAGE_MINMAX_THRESHOLD_TOP_MACROS_SVH

// same-cycle implication
`define MAMT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MAMT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/mamt_pkg.sv
// Package for the multichannel average / min-max / threshold block.
// Types, constants and the microcode ROM; no dependencies.
`default_nettype none

package mamt_pkg;

  localparam int CHANNELS_DEF = 6;
  localparam int WINDOW_DEF   = 5;

  localparam int CH_FIELD_W = 3;
  localparam int SMP_W      = 10;
  localparam int THR_W      = 7;
  localparam int MASK_W     = 6;
  localparam int PROD_W     = THR_W + SMP_W;

  localparam logic [THR_W-1:0] THR_RESET = 7'd80;
  localparam logic [THR_W-1:0] PCT_SCALE = 7'd100;
  localparam logic [SMP_W-1:0] SMP_MAX   = 10'd1023;

  localparam int STEP_W = 4;

  localparam logic [STEP_W-1:0] S_WAIT   = 4'd0;
  localparam logic [STEP_W-1:0] S_SETUP  = 4'd1;
  localparam logic [STEP_W-1:0] S_READ   = 4'd2;
  localparam logic [STEP_W-1:0] S_ACC    = 4'd3;
  localparam logic [STEP_W-1:0] S_DIV    = 4'd4;
  localparam logic [STEP_W-1:0] S_MINMAX = 4'd5;
  localparam logic [STEP_W-1:0] S_MULT   = 4'd6;
  localparam logic [STEP_W-1:0] S_LED    = 4'd7;
  localparam logic [STEP_W-1:0] S_EMIT   = 4'd8;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_WAIT,
    OP_SETUP,
    OP_READ,
    OP_ACC,
    OP_DIV,
    OP_MINMAX,
    OP_MULT,
    OP_LED,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_WAIT_IN,
    C_BAD,
    C_MORE,
    C_DIVMORE,
    C_OUTFREE
  } cond_t;

  typedef struct packed {
    cond_t             cond;
    op_t               op;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_fire;
    logic bad;
    logic more;
    logic div_more;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [CH_FIELD_W-1:0] channel;
    logic [SMP_W-1:0]      sample;
  } in_item_t;

  typedef struct packed {
    logic [CH_FIELD_W-1:0] out_channel;
    logic [SMP_W-1:0]      filtered;
    logic [SMP_W-1:0]      lowest;
    logic [SMP_W-1:0]      highest;
    logic                  led_on;
    logic [MASK_W-1:0]     led_mask;
  } out_item_t;

  // microcode program, one control word per step
  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] s);
    ctrl_word_t w;
    unique case (s)
      S_WAIT:   w = '{cond: C_WAIT_IN, op: OP_WAIT,   target: S_WAIT};
      S_SETUP:  w = '{cond: C_BAD,     op: OP_SETUP,  target: S_EMIT};
      S_READ:   w = '{cond: C_NEXT,    op: OP_READ,   target: S_READ};
      S_ACC:    w = '{cond: C_MORE,    op: OP_ACC,    target: S_READ};
      S_DIV:    w = '{cond: C_DIVMORE, op: OP_DIV,    target: S_DIV};
      S_MINMAX: w = '{cond: C_NEXT,    op: OP_MINMAX, target: S_WAIT};
      S_MULT:   w = '{cond: C_NEXT,    op: OP_MULT,   target: S_WAIT};
      S_LED:    w = '{cond: C_NEXT,    op: OP_LED,    target: S_WAIT};
      S_EMIT:   w = '{cond: C_OUTFREE, op: OP_EMIT,   target: S_WAIT};
      default:  w = '{cond: C_JUMP,    op: OP_NOP,    target: S_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hdl/mamt_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on mamt_pkg and the assertion macro header.
`default_nettype none
`include "multichannel_average_minmax_threshold_top_macros.svh"

module mamt_seq
  import mamt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output op_t     op
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ctrl_word_t        cw;

  assign cw = ucode(step);
  assign op = cw.op;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_WAIT;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    unique case (cw.cond)
      C_NEXT:    step_next = step + 1'b1;
      C_JUMP:    step_next = cw.target;
      C_WAIT_IN: step_next = status.in_fire  ? step + 1'b1 : cw.target;
      C_BAD:     step_next = status.bad      ? cw.target   : step + 1'b1;
      C_MORE:    step_next = status.more     ? cw.target   : step + 1'b1;
      C_DIVMORE: step_next = status.div_more ? cw.target   : step + 1'b1;
      C_OUTFREE: step_next = status.out_free ? cw.target   : step;
      default:   step_next = S_WAIT;
    endcase
  end

  `MAMT_ASSERT_IMP(a_step_range, 1'b1, step <= S_EMIT, "step counter left the program")
  `MAMT_ASSERT_NXT(a_fire_setup, status.in_fire, op == OP_SETUP, "accept not followed by setup")

endmodule

`default_nettype wire

// File: hdl/mamt_dp.sv
// Datapath: window memory, per-channel state, serial divider, threshold test,
// output register and config register. Driven by mamt_seq; uses mamt_pkg.
`default_nettype none
`include "multichannel_average_minmax_threshold_top_macros.svh"

module mamt_dp
  import mamt_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int WINDOW   = WINDOW_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  op_t              op,
  output status_t          status,
  input  logic             sample_valid,
  output logic             sample_ready,
  input  in_item_t         sample_data,
  output logic             result_valid,
  input  logic             result_ready,
  output out_item_t        result_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [THR_W-1:0] cfg_data
);

  localparam int DEPTH  = CHANNELS * WINDOW;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = SMP_W + $clog2(WINDOW);
  localparam int DCNT_W = $clog2(SUM_W);

  logic [SMP_W-1:0] mem [DEPTH];
  logic [SMP_W-1:0] rdata;

  logic [PW-1:0]    wpos   [CHANNELS];
  logic [CNT_W-1:0] fill   [CHANNELS];
  logic [SMP_W-1:0] run_min[CHANNELS];
  logic [SMP_W-1:0] run_max[CHANNELS];
  logic [CHANNELS-1:0] led;

  logic [THR_W-1:0]      thr;
  logic [CH_FIELD_W-1:0] ch;
  logic [SMP_W-1:0]      smp;
  logic                  bad;
  logic [AW-1:0]         base;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      j;
  logic [SUM_W-1:0]      sum;
  logic [SUM_W-1:0]      quot;
  logic [CNT_W-1:0]      rem;
  logic [DCNT_W-1:0]     dcnt;
  logic [SMP_W-1:0]      filt;
  logic [SMP_W-1:0]      lo;
  logic [SMP_W-1:0]      hi;
  logic [PROD_W-1:0]     p_level;
  logic [PROD_W-1:0]     p_span;
  logic                  span_ok;
  logic                  led_now;

  logic [CH_W-1:0]   ch_idx;
  logic [PW-1:0]     pos;
  logic [CNT_W-1:0]  cnt_new;
  logic [AW-1:0]     base_c;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic [CNT_W-1:0]  j_inc;
  logic [SUM_W-1:0]  sum_acc;
  logic [CNT_W:0]    trial;
  logic              ge;
  logic [SMP_W-1:0]  q_filt;
  logic [SMP_W-1:0]  lo_new;
  logic [SMP_W-1:0]  hi_new;
  logic [MASK_W-1:0] mask;
  logic              in_fire;
  logic              out_free;

  assign sample_ready = (op == OP_WAIT) && !rst;
  assign in_fire      = sample_valid && sample_ready;
  assign out_free     = !result_valid || result_ready;
  assign cfg_ready    = !rst;

  assign ch_idx  = CH_W'(ch);
  assign pos     = wpos[ch_idx];
  assign cnt_new = (fill[ch_idx] < CNT_W'(WINDOW)) ? fill[ch_idx] + 1'b1 : fill[ch_idx];
  assign base_c  = AW'(ch_idx * WINDOW);
  assign wr_addr = AW'(base_c + pos);
  assign rd_addr = AW'(base + j);
  assign j_inc   = j + 1'b1;
  assign sum_acc = sum + SUM_W'(rdata);
  assign trial   = {rem, quot[SUM_W-1]};
  assign ge      = trial >= {1'b0, cnt};
  assign q_filt  = quot[SMP_W-1:0];
  assign lo_new  = (q_filt < run_min[ch_idx]) ? q_filt : run_min[ch_idx];
  assign hi_new  = (q_filt > run_max[ch_idx]) ? q_filt : run_max[ch_idx];

  assign status.in_fire  = in_fire;
  assign status.bad      = bad;
  assign status.more     = (j_inc != cnt);
  assign status.div_more = (dcnt != DCNT_W'(SUM_W - 1));
  assign status.out_free = out_free;

  // bits beyond the channel count read as zero
  for (genvar i = 0; i < MASK_W; i++) begin : g_mask
    if (i < CHANNELS) begin : g_on
      assign mask[i] = led[i];
    end else begin : g_off
      assign mask[i] = 1'b0;
    end
  end

  // window memory, contents undefined until written
  always_ff @(posedge clk) begin
    if (op == OP_SETUP && !bad) begin
      mem[wr_addr] <= smp;
    end
    if (op == OP_READ) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr <= cfg_data;
    end
  end

  // per-channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wpos[c]    <= '0;
        fill[c]    <= '0;
        run_min[c] <= SMP_MAX;
        run_max[c] <= '0;
      end
      led <= '0;
    end else begin
      if (op == OP_SETUP && !bad) begin
        wpos[ch_idx] <= (pos == PW'(WINDOW - 1)) ? '0 : pos + 1'b1;
        fill[ch_idx] <= cnt_new;
      end
      if (op == OP_MINMAX) begin
        run_min[ch_idx] <= lo_new;
        run_max[ch_idx] <= hi_new;
      end
      if (op == OP_LED) begin
        led[ch_idx] <= span_ok && (p_level >= p_span);
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (op)
      OP_WAIT: begin
        if (in_fire) begin
          ch  <= sample_data.channel;
          smp <= sample_data.sample;
          bad <= 32'(sample_data.channel) >= 32'(CHANNELS);
        end
      end
      OP_SETUP: begin
        base <= base_c;
        cnt  <= cnt_new;
        j    <= '0;
        sum  <= '0;
      end
      OP_ACC: begin
        sum  <= sum_acc;
        quot <= sum_acc;
        j    <= j_inc;
        rem  <= '0;
        dcnt <= '0;
      end
      OP_DIV: begin
        // restoring division, one quotient bit per step
        rem  <= ge ? CNT_W'(trial - {1'b0, cnt}) : trial[CNT_W-1:0];
        quot <= {quot[SUM_W-2:0], ge};
        dcnt <= dcnt + 1'b1;
      end
      OP_MINMAX: begin
        filt <= q_filt;
        lo   <= lo_new;
        hi   <= hi_new;
      end
      OP_MULT: begin
        p_level <= PROD_W'(PCT_SCALE) * PROD_W'(filt - lo);
        p_span  <= PROD_W'(thr) * PROD_W'(hi - lo);
        span_ok <= hi > lo;
      end
      OP_LED: begin
        led_now <= span_ok && (p_level >= p_span);
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (op == OP_EMIT && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_EMIT && out_free) begin
      result_data.out_channel <= ch;
      result_data.led_mask    <= mask;
      if (bad) begin
        result_data.filtered <= '0;
        result_data.lowest   <= '0;
        result_data.highest  <= '0;
        result_data.led_on   <= 1'b0;
      end else begin
        result_data.filtered <= filt;
        result_data.lowest   <= lo;
        result_data.highest  <= hi;
        result_data.led_on   <= led_now;
      end
    end
  end

  `MAMT_ASSERT_IMP(a_filt_in_span, op == OP_MULT, (lo <= filt) && (filt <= hi), "filtered outside min/max")
  `MAMT_ASSERT_IMP(a_rem_below, op == OP_DIV, rem < cnt, "divider remainder not below divisor")
  `MAMT_ASSERT_IMP(a_cnt_nonzero, op == OP_ACC, (cnt != '0) && (j < cnt), "summing past fill count")

endmodule

`default_nettype wire

// File: hdl/multichannel_average_minmax_threshold_top.sv
// Multichannel moving average with running min/max and threshold LED bits.
//
// sample channel (valid/ready): one transaction carries a channel number and a
// 10-bit reading. result channel (valid/ready): exactly one transaction per
// sample, in order. cfg channel (valid/ready, ready outside reset): writes the
// threshold percentage; write it only while the block is idle.
// The sample goes into the channel's circular window; the filled entries are
// summed by a microcoded sequencer (one memory read and one add per entry),
// then divided by the fill count in a restoring divider, one bit per cycle.
// The divider works on the SUM_W-bit sum, where SUM_W = 10 + clog2(WINDOW).
// The emit step loads the result into the output register.
// A result waiting in the output register does not block the next sample;
// if the receiver stalls, the sequencer holds at the emit step until the
// output register frees up. Reset clears positions, fill counts, min/max,
// LED bits and sets the threshold to 80; the window memory is not cleared.
// Depends on mamt_pkg, mamt_seq and mamt_dp.
`default_nettype none

module multichannel_average_minmax_threshold_top
  import mamt_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int WINDOW   = WINDOW_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_ready,
  input  in_item_t         sample_data,
  output logic             result_valid,
  input  logic             result_ready,
  output out_item_t        result_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [THR_W-1:0] cfg_data
);

  op_t     op;
  status_t status;

  mamt_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .op     (op)
  );

  mamt_dp #(
    .CHANNELS (CHANNELS),
    .WINDOW   (WINDOW)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .status       (status),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_data  (sample_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

endmodule

`default_nettype wire

// File: tb/multichannel_average_minmax_threshold_top_tb.sv
// Testbench for multichannel_average_minmax_threshold_top: moving average, min/max, LED bits.
// Holds its own model of the channel windows in a small class. Plain tasks drive the ports.
// Depends on mamt_pkg and the block's RTL only.
`timescale 1ns / 1ps

module multichannel_average_minmax_threshold_top_tb;
  import mamt_pkg::*;

  localparam int PHASE_ITEMS = 185;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD_AT = 300;
  localparam int LONG_HOLD_CYCLES = 500;

  class channel_filter_tracker;
    logic [SMP_W-1:0]  window [CHANNELS_DEF][WINDOW_DEF];
    int unsigned       wr_pos [CHANNELS_DEF];
    int unsigned       fill [CHANNELS_DEF];
    int unsigned       lo_seen [CHANNELS_DEF];
    int unsigned       hi_seen [CHANNELS_DEF];
    logic [MASK_W-1:0] led_bits;
    logic [THR_W-1:0]  threshold;
    out_item_t         expected_readings [$];
    int                errors;

    function new();
      threshold = THR_RESET;
      led_bits = '0;
      errors = 0;
      foreach (wr_pos[c]) begin
        wr_pos[c] = 0;
        fill[c] = 0;
        lo_seen[c] = SMP_MAX;
        hi_seen[c] = 0;
      end
    endfunction

    function void set_threshold(logic [THR_W-1:0] pct);
      threshold = pct;
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction

    // work out the result of one accepted sample transaction
    function void predict_reading(in_item_t item);
      out_item_t   r;
      int unsigned ch, sum, avg, lo, hi, j;
      logic        led;
      r = '0;
      r.out_channel = item.channel;
      ch = item.channel;
      if (ch < CHANNELS_DEF) begin
        window[ch][wr_pos[ch]] = item.sample;
        wr_pos[ch] = (wr_pos[ch] + 1) % WINDOW_DEF;
        if (fill[ch] < WINDOW_DEF) fill[ch]++;
        sum = 0;
        for (j = 0; j < fill[ch]; j++) sum += window[ch][j];
        avg = sum / fill[ch];
        if (avg < lo_seen[ch]) lo_seen[ch] = avg;
        if (avg > hi_seen[ch]) hi_seen[ch] = avg;
        lo = lo_seen[ch];
        hi = hi_seen[ch];
        led = (hi > lo) && (100 * (avg - lo) >= threshold * (hi - lo));
        led_bits[ch] = led;
        r.filtered = SMP_W'(avg);
        r.lowest = SMP_W'(lo);
        r.highest = SMP_W'(hi);
        r.led_on = led;
      end
      // out-of-range channel: all zero but the channel and the LED mask
      r.led_mask = led_bits;
      expected_readings.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_reading(out_item_t got);
      out_item_t want;
      if (expected_readings.size() == 0) begin
        $display("%0t: result transaction with nothing expected: %h", $time, got);
        errors++;
      end else begin
        want = expected_readings.pop_front();
        compare_field("out_channel", want.out_channel, got.out_channel);
        compare_field("filtered", want.filtered, got.filtered);
        compare_field("lowest", want.lowest, got.lowest);
        compare_field("highest", want.highest, got.highest);
        compare_field("led_on", want.led_on, got.led_on);
        compare_field("led_mask", want.led_mask, got.led_mask);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             sample_valid;
  logic             sample_ready;
  in_item_t         sample_data;
  logic             result_valid;
  logic             result_ready;
  out_item_t        result_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [THR_W-1:0] cfg_data;

  channel_filter_tracker tracker;
  int gap_max;
  int walk [8];
  int results_seen;

  multichannel_average_minmax_threshold_top dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_data  (sample_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_500_000;
    $display("*** FAILED ***");
    $finish;
  end

  // valid is only lowered when a gap is drawn, so back-to-back items keep it high
  task automatic send_sample(input logic [CH_FIELD_W-1:0] ch, input logic [SMP_W-1:0] smp);
    int       gap;
    in_item_t item;
    gap = $urandom_range(0, gap_max);
    item.channel = ch;
    item.sample = smp;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_data <= item;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    tracker.predict_reading(item);
  endtask

  // lower valid, then hold off until every result has come back
  task automatic drain_results();
    sample_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] pct);
    cfg_valid <= 1'b1;
    cfg_data <= pct;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_threshold(pct);
    cfg_valid <= 1'b0;
  endtask

  // mostly slow random walks per channel, so the LED crosses its threshold
  function automatic logic [SMP_W-1:0] pick_sample(int ch);
    int kind;
    int step;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      step = int'($urandom_range(0, 128)) - 64;
      walk[ch] = walk[ch] + step;
      if (walk[ch] < 0) walk[ch] = 0;
      if (walk[ch] > SMP_MAX) walk[ch] = SMP_MAX;
      return SMP_W'(walk[ch]);
    end else if (kind <= 7) begin
      return SMP_W'($urandom_range(0, SMP_MAX));
    end else if (kind == 8) begin
      return $urandom_range(0, 1) ? SMP_MAX : '0;
    end
    return SMP_W'($urandom_range(0, 15));
  endfunction

  task automatic random_phase(input int count);
    int ch;
    repeat (count) begin
      if ($urandom_range(0, 19) == 0) ch = $urandom_range(CHANNELS_DEF, 7);
      else ch = $urandom_range(0, CHANNELS_DEF - 1);
      send_sample(CH_FIELD_W'(ch), pick_sample(ch));
    end
  endtask

  // receiver: random stall per transaction, one long hold-off to back up the block
  initial begin
    int gap;
    result_ready <= 1'b0;
    results_seen = 0;
    do @(posedge clk); while (rst);
    forever begin
      gap = (results_seen == LONG_HOLD_AT) ? LONG_HOLD_CYCLES : $urandom_range(0, gap_max);
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      tracker.check_reading(result_data);
      results_seen++;
    end
  end

  initial begin
    logic [THR_W-1:0] settings [7];
    tracker = new();
    foreach (walk[c]) walk[c] = 512;
    gap_max = 4;
    rst <= 1'b1;
    sample_valid <= 1'b0;
    sample_data <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, window wrap, out-of-range channels, flat spans
    send_sample(0, 0);
    send_sample(0, SMP_MAX);
    send_sample(0, SMP_MAX);
    send_sample(0, 0);
    send_sample(0, 512);
    send_sample(0, SMP_MAX);
    send_sample(0, SMP_MAX);
    send_sample(7, SMP_MAX);
    send_sample(6, 0);
    send_sample(5, SMP_MAX);
    send_sample(5, 0);
    send_sample(1, 0);
    send_sample(1, 0);
    send_sample(2, 10'h2AA);
    send_sample(3, 10'h155);
    send_sample(4, SMP_MAX);
    send_sample(4, 0);
    send_sample(4, SMP_MAX);
    send_sample(3, 0);
    send_sample(2, 0);
    send_sample(5, SMP_MAX);
    drain_results();

    random_phase(PHASE_ITEMS);
    drain_results();

    settings = '{7'd0, 7'd100, 7'd127, 7'd1, 7'd99, 7'd50, 7'd0};
    settings[6] = THR_W'($urandom_range(0, 127));
    foreach (settings[i]) begin
      write_threshold(settings[i]);
      gap_max = (i == 3) ? 0 : 4;  // one stretch with no idling on either side
      random_phase(PHASE_ITEMS);
      drain_results();
    end

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
